// ===== rtl/xxh_pkg.sv =====
// Package: xxHash64 constants, sequencer states, multiply request type and rotate.
package xxh_pkg;

   localparam logic [63:0] PRIME1 = 64'd11400714785074694791;
   localparam logic [63:0] PRIME2 = 64'd14029467366897019727;
   localparam logic [63:0] PRIME3 = 64'd1609587929392839161;
   localparam logic [63:0] PRIME4 = 64'd9650029242287828579;
   localparam logic [63:0] PRIME5 = 64'd2870177450012600261;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LANE_MUL,
      ST_LANE_ROT,
      ST_LANE_ROT2,
      ST_MERGE_SUM,
      ST_MERGE_MUL,
      ST_MERGE_ROT,
      ST_MERGE_XOR,
      ST_LEN,
      ST_W8_MUL,
      ST_W8_ROT,
      ST_W8_XOR,
      ST_W4_MUL,
      ST_W4_XOR,
      ST_B1_MUL,
      ST_B1_XOR,
      ST_AV1,
      ST_AV2,
      ST_AV3,
      ST_DONE
   } state_type;

   // 64x64 low-half multiply split into 32-bit partial products.
   typedef struct packed {
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   function automatic logic [63:0] rotl(input logic [63:0] x, input logic [5:0] r);
      rotl = (x << r) | (x >> (7'd64 - {1'b0, r}));
   endfunction

endpackage

// ===== rtl/xxh_if.sv =====
// Interfaces: request and response channels.
interface xxh_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] data_word;
   logic [3:0]  bytes_valid;
   logic        last;
   modport source (output valid, data_word, bytes_valid, last, input ready);
   modport sink (input valid, data_word, bytes_valid, last, output ready);
endinterface

interface xxh_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;
   modport source (output valid, hash_value, input ready);
   modport sink (input valid, hash_value, output ready);
endinterface

// ===== rtl/xxhash64_stream_hasher.sv =====
// Top level: streaming xxHash64 with seed zero on one shared multiplier.
// A non-last word that does not complete a stripe is taken in ST_IDLE; a stripe-completing
// word holds the input while the four lane rounds run (LANE_MUL, LANE_ROT, LANE_ROT2).
// A last word shows its hash after merge (for 32 bytes or more), tails and avalanche;
// every multiply in those rounds goes through the single shared multiplier.
// Throughput: one word at a time; req.ready is low while a word is in work.
// Reset: synchronous; lanes return to seed-zero start values, counts clear.
module xxhash64_stream_hasher
   import xxh_pkg::*;
(
   input logic      clock,
   input logic      reset,
   xxh_req_if.sink  req,
   xxh_rsp_if.source rsp
);
   state_type   state_ff, state_in;
   logic [63:0] lane_ff [4];
   logic [63:0] lane_in [4];
   logic [63:0] buf_ff [3];
   logic [1:0]  cnt_ff, cnt_in;
   logic [63:0] len_ff, len_in;
   logic [63:0] w_ff, w_in;
   logic [3:0]  rem_ff, rem_in;
   logic        last_ff, last_in;
   logic [63:0] h_ff, h_in;
   logic [63:0] t_ff, t_in;
   logic [1:0]  idx_ff, idx_in;
   logic [2:0]  pos_ff, pos_in;
   logic        ph_ff, ph_in;
   logic        wr_buf;
   mul_req_type mreq;
   logic [63:0] prod;
   logic [3:0]  n;
   logic [63:0] wm;
   logic [63:0] lane_cur, word_cur, byte_cur;

   xxh_mul u_mul (.clock(clock), .req(mreq), .prod(prod));

   always_comb begin
      n = (!req.last || req.bytes_valid > 4'd8) ? 4'd8 : req.bytes_valid;
      wm = (n == 4'd8) ? req.data_word : req.data_word & ((64'd1 << {n, 3'b000}) - 64'd1);
      lane_cur = lane_ff[idx_ff];
      word_cur = (idx_ff == 2'd3) ? w_ff : buf_ff[idx_ff];
      byte_cur = {56'd0, 8'(w_ff >> {pos_ff, 3'b000})};
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) begin
            if (n == 4'd8 && cnt_ff == 2'd3) state_in = ST_LANE_MUL;
            else if (req.last) state_in = ST_LEN;
         end
         ST_LANE_MUL:  if (ph_ff) state_in = ST_LANE_ROT;
         ST_LANE_ROT:  state_in = ST_LANE_ROT2;
         ST_LANE_ROT2: if (ph_ff) state_in = (idx_ff == 2'd3)
                          ? (last_ff ? ST_LEN : ST_IDLE) : ST_LANE_MUL;
         ST_MERGE_SUM: state_in = ST_MERGE_MUL;
         ST_MERGE_MUL: if (ph_ff) state_in = ST_MERGE_ROT;
         ST_MERGE_ROT: if (ph_ff) state_in = ST_MERGE_XOR;
         ST_MERGE_XOR: if (ph_ff) state_in = (idx_ff == 2'd3) ? ST_W8_MUL : ST_MERGE_MUL;
         ST_LEN: state_in = (len_ff >= 64'd32) ? ST_MERGE_SUM : ST_W8_MUL;
         ST_W8_MUL: if (idx_ff >= cnt_ff) state_in = ST_W4_MUL;
                    else if (ph_ff) state_in = ST_W8_ROT;
         ST_W8_ROT: if (ph_ff) state_in = ST_W8_XOR;
         ST_W8_XOR: if (ph_ff) state_in = ST_W8_MUL;
         ST_W4_MUL: if (rem_ff < 4'd4) state_in = ST_B1_MUL;
                    else if (ph_ff) state_in = ST_W4_XOR;
         ST_W4_XOR: if (ph_ff) state_in = ST_B1_MUL;
         ST_B1_MUL: if ({1'b0, pos_ff} >= rem_ff) state_in = ST_AV1;
                    else if (ph_ff) state_in = ST_B1_XOR;
         ST_B1_XOR: if (ph_ff) state_in = ST_B1_MUL;
         ST_AV1: if (ph_ff) state_in = ST_AV2;
         ST_AV2: if (ph_ff) state_in = ST_AV3;
         ST_AV3: state_in = ST_DONE;
         ST_DONE: if (rsp.ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      for (int i = 0; i < 4; i++) lane_in[i] = lane_ff[i];
      cnt_in = cnt_ff; len_in = len_ff; w_in = w_ff; rem_in = rem_ff;
      last_in = last_ff; h_in = h_ff; t_in = t_ff; idx_in = idx_ff;
      pos_in = pos_ff; ph_in = 1'b0; wr_buf = 1'b0;
      mreq = '{a: word_cur, b: PRIME2};
      req.ready = (state_ff == ST_IDLE);
      rsp.valid = (state_ff == ST_DONE);
      rsp.hash_value = h_ff;
      case (state_ff)
         ST_IDLE: if (req.valid) begin
            len_in = len_ff + 64'(n);
            w_in = wm; last_in = req.last; idx_in = 2'd0; pos_in = 3'd0;
            rem_in = (n == 4'd8) ? 4'd0 : n;
            if (n == 4'd8 && cnt_ff != 2'd3) begin
               wr_buf = 1'b1; cnt_in = cnt_ff + 2'd1;
            end
         end
         ST_LANE_MUL: begin
            mreq = '{a: word_cur, b: PRIME2}; ph_in = !ph_ff;
            if (ph_ff) t_in = rotl(lane_cur + prod, 6'd31);
         end
         ST_LANE_ROT: ;
         ST_LANE_ROT2: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) begin
               lane_in[idx_ff] = prod; idx_in = idx_ff + 2'd1;
               if (idx_ff == 2'd3) cnt_in = 2'd0;
            end
         end
         ST_MERGE_SUM: begin
            h_in = rotl(lane_ff[0], 6'd1) + rotl(lane_ff[1], 6'd7)
                 + rotl(lane_ff[2], 6'd12) + rotl(lane_ff[3], 6'd18);
            idx_in = 2'd0;
         end
         ST_MERGE_MUL: begin
            mreq = '{a: lane_cur, b: PRIME2}; ph_in = !ph_ff;
            if (ph_ff) t_in = rotl(prod, 6'd31);
         end
         ST_MERGE_ROT: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) t_in = h_ff ^ prod;
         end
         ST_MERGE_XOR: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) begin
               h_in = prod + PRIME4 + ((idx_ff == 2'd3) ? len_ff : 64'd0);
               idx_in = (idx_ff == 2'd3) ? 2'd0 : idx_ff + 2'd1;
            end
         end
         ST_LEN: begin
            h_in = PRIME5 + len_ff; idx_in = 2'd0;
            if (len_ff >= 64'd32) h_in = 64'd0 + len_ff;
         end
         ST_W8_MUL: begin
            mreq = '{a: buf_ff[idx_ff], b: PRIME2};
            if (idx_ff < cnt_ff) begin
               ph_in = !ph_ff;
               if (ph_ff) t_in = rotl(prod, 6'd31);
            end
         end
         ST_W8_ROT: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) t_in = rotl(h_ff ^ prod, 6'd27);
         end
         ST_W8_XOR: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) begin h_in = prod + PRIME4; idx_in = idx_ff + 2'd1; end
         end
         ST_W4_MUL: begin
            mreq = '{a: {32'd0, w_ff[31:0]}, b: PRIME1};
            if (rem_ff >= 4'd4) begin
               ph_in = !ph_ff;
               if (ph_ff) t_in = rotl(h_ff ^ prod, 6'd23);
            end
         end
         ST_W4_XOR: begin
            mreq = '{a: t_ff, b: PRIME2}; ph_in = !ph_ff;
            if (ph_ff) begin h_in = prod + PRIME3; pos_in = 3'd4; end
         end
         ST_B1_MUL: begin
            mreq = '{a: byte_cur, b: PRIME5};
            if ({1'b0, pos_ff} < rem_ff) begin
               ph_in = !ph_ff;
               if (ph_ff) t_in = rotl(h_ff ^ prod, 6'd11);
            end
         end
         ST_B1_XOR: begin
            mreq = '{a: t_ff, b: PRIME1}; ph_in = !ph_ff;
            if (ph_ff) begin h_in = prod; pos_in = pos_ff + 3'd1; end
         end
         ST_AV1: begin
            mreq = '{a: h_ff ^ (h_ff >> 33), b: PRIME2}; ph_in = !ph_ff;
            if (ph_ff) h_in = prod;
         end
         ST_AV2: begin
            mreq = '{a: h_ff ^ (h_ff >> 29), b: PRIME3}; ph_in = !ph_ff;
            if (ph_ff) h_in = prod;
         end
         ST_AV3: h_in = h_ff ^ (h_ff >> 32);
         ST_DONE: if (rsp.ready) begin
            lane_in[0] = PRIME1 + PRIME2; lane_in[1] = PRIME2;
            lane_in[2] = 64'd0; lane_in[3] = 64'd0 - PRIME1;
            cnt_in = 2'd0; len_in = 64'd0;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lane_ff[0] <= PRIME1 + PRIME2; lane_ff[1] <= PRIME2;
         lane_ff[2] <= 64'd0; lane_ff[3] <= 64'd0 - PRIME1;
         cnt_ff <= 2'd0; len_ff <= 64'd0; ph_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         for (int i = 0; i < 4; i++) lane_ff[i] <= lane_in[i];
         cnt_ff <= cnt_in; len_ff <= len_in; ph_ff <= ph_in;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in; rem_ff <= rem_in; last_ff <= last_in; h_ff <= h_in;
      t_ff <= t_in; idx_ff <= idx_in; pos_ff <= pos_in;
      if (wr_buf) buf_ff[cnt_ff] <= wm;
   end

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while result pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.hash_value))
      else $error("result dropped");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready |=> len_ff == 64'd0 && cnt_ff == 2'd0)
      else $error("state not cleared");
endmodule

// ===== rtl/xxh_mul.sv =====
// Shared unit: 64-bit low-half multiply; partial products are registered in lo_ff and cr_ff.
module xxh_mul
   import xxh_pkg::*;
(
   input  logic        clock,
   input  mul_req_type req,
   output logic [63:0] prod
);
   logic [63:0] lo_ff, lo_in;
   logic [31:0] cr_ff, cr_in;

   always_comb begin
      lo_in = req.a[31:0] * req.b[31:0];
      cr_in = 32'(req.a[31:0] * req.b[63:32]) + 32'(req.a[63:32] * req.b[31:0]);
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      cr_ff <= cr_in;
   end

   assign prod = {lo_ff[63:32] + cr_ff, lo_ff[31:0]};
endmodule

// ===== tb/xxhash64_stream_hasher_tb.sv =====
// Testbench: streaming xxHash64 checked against a built-in predictor of the hash.
module xxhash64_stream_hasher_tb;
   import xxh_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [63:0] data_word;
      logic [3:0]  bytes_valid;
      logic        last;
      logic        known;
      logic [63:0] hash_value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   xxh_req_if req ();
   xxh_rsp_if rsp ();

   xxhash64_stream_hasher u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #4 clock = ~clock;

   logic [63:0] hash_queue[$];
   logic [63:0] lane[4];
   logic [63:0] stripe_word[3];
   int unsigned stripe_cnt;
   logic [63:0] msg_len;

   int          error_count;
   int          mismatch_count;
   int          hash_count;
   int          word_count;
   int          idle_cycles;
   bit          stim_done;
   bit          rsp_burst_off;
   bit          long_hold;
   bit          hold_done;

   stim_row_type rows[$];

   function automatic logic [63:0] rot64(logic [63:0] x, int r);
      return (x << r) | (x >> (64 - r));
   endfunction

   function automatic logic [63:0] mix_round(logic [63:0] acc, logic [63:0] w);
      acc = acc + w * PRIME2;
      acc = rot64(acc, 31);
      return acc * PRIME1;
   endfunction

   task automatic restart_msg();
      lane[0]    = PRIME1 + PRIME2;
      lane[1]    = PRIME2;
      lane[2]    = 64'd0;
      lane[3]    = 64'd0 - PRIME1;
      stripe_cnt = 0;
      msg_len    = 64'd0;
   endtask

   // Absorb one word; push a hash when it ends the message.
   task automatic absorb_word(logic [63:0] w, logic [3:0] bv, logic lst);
      int unsigned n;
      int unsigned rem;
      int unsigned pos;
      logic [63:0] h;
      n = bv;
      if (!lst || n > 8) n = 8;
      if (n < 8) w = w & ((64'd1 << (8 * n)) - 64'd1);
      msg_len = msg_len + n;
      rem = n;
      if (n == 8) begin
         rem = 0;
         if (stripe_cnt >= 3) begin
            lane[0] = mix_round(lane[0], stripe_word[0]);
            lane[1] = mix_round(lane[1], stripe_word[1]);
            lane[2] = mix_round(lane[2], stripe_word[2]);
            lane[3] = mix_round(lane[3], w);
            stripe_cnt = 0;
         end else begin
            stripe_word[stripe_cnt] = w;
            stripe_cnt++;
         end
      end
      if (!lst) return;
      if (msg_len >= 64'd32) begin
         h = rot64(lane[0], 1) + rot64(lane[1], 7) + rot64(lane[2], 12)
             + rot64(lane[3], 18);
         for (int i = 0; i < 4; i++) begin
            h = h ^ mix_round(64'd0, lane[i]);
            h = h * PRIME1 + PRIME4;
         end
      end else begin
         h = PRIME5;
      end
      h = h + msg_len;
      for (int i = 0; i < stripe_cnt; i++) begin
         h = h ^ mix_round(64'd0, stripe_word[i]);
         h = rot64(h, 27) * PRIME1 + PRIME4;
      end
      pos = 0;
      if (rem >= 4) begin
         h = h ^ ({32'd0, w[31:0]} * PRIME1);
         h = rot64(h, 23) * PRIME2 + PRIME3;
         pos = 4;
      end
      for (; pos < rem; pos++) begin
         h = h ^ ({56'd0, w[8*pos +: 8]} * PRIME5);
         h = rot64(h, 11) * PRIME1;
      end
      h = h ^ (h >> 33);
      h = h * PRIME2;
      h = h ^ (h >> 29);
      h = h * PRIME3;
      h = h ^ (h >> 32);
      hash_queue.push_back(h);
      restart_msg();
   endtask

   function automatic stim_row_type mk(logic [63:0] w, logic [3:0] bv, logic lst,
                                       logic kn = 1'b0, logic [63:0] hv = 64'd0);
      stim_row_type r;
      r.data_word   = w;
      r.bytes_valid = bv;
      r.last        = lst;
      r.known       = kn;
      r.hash_value  = hv;
      return r;
   endfunction

   task automatic build_rows();
      // empty message: well-known seed-zero hash
      rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b1, 1'b1, 64'hEF46DB3751D8E999));
      rows.push_back(mk(64'h0, 4'd1, 1'b1));
      rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b1));
      rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd4, 1'b1));
      rows.push_back(mk(64'h0123_4567_89AB_CDEF, 4'd7, 1'b1));
      rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1));
      rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1));
      rows.push_back(mk(64'h1111_2222_3333_4444, 4'd2, 1'b0));
      rows.push_back(mk(64'hAAAA_5555_AAAA_5555, 4'd5, 1'b1));
      for (int i = 0; i < 4; i++)
         rows.push_back(mk({$urandom, $urandom}, 4'd8, 1'b0));
      rows.push_back(mk(64'h0, 4'd0, 1'b1));
      for (int i = 0; i < 7; i++)
         rows.push_back(mk(64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 1'b0));
      rows.push_back(mk(64'hDEAD_BEEF_CAFE_F00D, 4'd6, 1'b1));
      for (int i = 0; i < 3; i++)
         rows.push_back(mk(64'h0, 4'd8, 1'b0));
      rows.push_back(mk(64'h0, 4'd8, 1'b1));
   endtask

   task automatic send_word(stim_row_type r);
      if (!stim_done && $urandom_range(0, 5) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req.valid       <= 1'b1;
      req.data_word   <= r.data_word;
      req.bytes_valid <= r.bytes_valid;
      req.last        <= r.last;
      do @(posedge clock); while (!req.ready);
      word_count++;
      if (r.known) hash_queue.push_back(r.hash_value);
      else absorb_word(r.data_word, r.bytes_valid, r.last);
      if (r.known) restart_msg();
   endtask

   function automatic stim_row_type rand_row(bit lst);
      stim_row_type r;
      r = mk({$urandom, $urandom}, 4'($urandom_range(0, 15)), lst);
      if (!lst && $urandom_range(0, 3) != 0) r.bytes_valid = 4'd8;
      if (lst && $urandom_range(0, 2) != 0) r.bytes_valid = 4'($urandom_range(0, 8));
      return r;
   endfunction

   initial begin
      int len;
      req.valid       = 1'b0;
      req.data_word   = 64'd0;
      req.bytes_valid = 4'd0;
      req.last        = 1'b0;
      restart_msg();
      build_rows();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[i]) send_word(rows[i]);
      while (word_count < 1950) begin
         if (word_count > 1650) stim_done = 1'b1;
         if (word_count > 600 && !hold_done) long_hold = 1'b1;
         len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
         for (int k = 0; k < len; k++) send_word(rand_row(1'b0));
         send_word(rand_row(1'b1));
      end
      req.valid <= 1'b0;
      while (hash_queue.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      $display("Sent %0d words, checked %0d hashes (short tails, stripes, overlong counts,",
               word_count, hash_count);
      $display("  empty messages, a long receiver hold).");
      if (error_count == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

   // Response side: random stall bursts, one long hold.
   initial begin
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold && !hold_done) begin
            rsp.ready <= 1'b0;
            repeat (3000) @(posedge clock);
            hold_done = 1'b1;
            long_hold = 1'b0;
         end else if (!stim_done && $urandom_range(0, 4) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         hash_count <= hash_count + 1;
         if (hash_queue.size() == 0) begin
            error_count++;
            if (mismatch_count++ < 10)
               $display("unexpected hash %h", rsp.hash_value);
         end else if (hash_queue[0] !== rsp.hash_value) begin
            error_count++;
            if (mismatch_count++ < 10)
               $display("hash mismatch: expected %h actual %h", hash_queue[0],
                        rsp.hash_value);
            void'(hash_queue.pop_front());
         end else begin
            void'(hash_queue.pop_front());
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 20000) begin
         $display("== FAIL ==");
         $finish;
      end
   end

endmodule
